/* design/bbe_pkg.sv */
// Shared types and constants for the B-spline basis evaluator.
// Depends on nothing; imported by bbe_front, bbe_cell and the top level.
package bbe_pkg;

  localparam int GRID_INTERVALS = 8;
  localparam int BASIS_DEGREE   = 3;

  localparam int N_ORDER0  = GRID_INTERVALS + 2 * BASIS_DEGREE;
  localparam int N_BASIS   = GRID_INTERVALS + BASIS_DEGREE;
  localparam int ONE_Q15   = 32768;
  localparam int CLAMP_LOG = 24;

  // Knot-axis position u = (x + 1) * GRID_INTERVALS / 2 + BASIS_DEGREE, unit 2^-15 spacing
  localparam int U_MAX = 49151 * GRID_INTERVALS + BASIS_DEGREE * ONE_Q15;
  localparam int U_OFS = 16384 * GRID_INTERVALS + BASIS_DEGREE * ONE_Q15;
  localparam int U_W   = $clog2(U_MAX + 1) + 1;
  localparam int SP_W  = U_W - 16;

  // Distances u - j and (j + p + 1) - u
  localparam int L_MAG = U_MAX + (N_ORDER0 + 1) * ONE_Q15;
  localparam int L_W   = $clog2(L_MAG + 1) + 1;

  // Intermediate basis values, clamped to +/- 2^24
  localparam int V_W    = CLAMP_LOG + 2;
  localparam int P_W    = L_W + V_W;
  localparam int QS_W   = P_W + 1 - 15;
  localparam int Q_W    = CLAMP_LOG + 1 + $clog2(BASIS_DEGREE + 1);
  localparam int REC_SH = 31;
  localparam int REC_W  = 32;

  localparam int IDX_W = $clog2(N_BASIS + 1);
  localparam int ORD_W = $clog2(BASIS_DEGREE + 2);
  localparam int J_W   = $clog2(N_ORDER0 + 1) + 1;
  localparam int CMP_W = SP_W + J_W;

  localparam int DATA_W = 24;

  typedef logic signed [V_W-1:0] val_t;
  typedef val_t [BASIS_DEGREE:0] window_t;

  localparam val_t ONE_V   = V_W'(ONE_Q15);
  localparam val_t CLAMP_V = V_W'(1 << CLAMP_LOG);

  // Request travelling down the chain alongside the basis values
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [IDX_W-1:0]      idx;
    logic signed [U_W-1:0] u;
  } tag_t;

  // Fixed role of one recurrence cell
  typedef struct packed {
    logic [ORD_W-1:0] ord;
    logic [ORD_W-1:0] offset;
    logic [REC_W-1:0] recip;
  } coef_t;

endpackage

/* design/bbe_cell.sv */
// One Cox-de Boor recurrence cell: N[j,p] from N[j,p-1] and N[j+1,p-1].
// Four register stages; uses bbe_pkg types and widths.
module bbe_cell
  import bbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  coef_t coef,
  input  tag_t  tag_in,
  input  val_t  a,
  input  val_t  b,
  output tag_t  tag_out,
  output val_t  val_out
);

  tag_t t1, t2, t3;

  logic signed [L_W-1:0]  jl;
  logic signed [L_W-1:0]  lnum;
  logic signed [L_W-1:0]  rnum;
  logic signed [P_W-1:0]  prod_l;
  logic signed [P_W-1:0]  prod_r;

  logic signed [P_W:0]    sum;
  logic signed [QS_W-1:0] q;
  logic signed [QS_W-1:0] q_hi;
  logic signed [QS_W-1:0] q_lo;
  logic signed [QS_W-1:0] q_base;
  logic signed [QS_W-1:0] qc;
  logic [Q_W-1:0]         qo;

  logic [Q_W+REC_W-1:0]   scaled;
  logic [V_W-1:0]         quo;

  // Distances to the knots on either side of this term
  always_comb begin
    jl   = L_W'(tag_in.idx) + L_W'(coef.offset);
    lnum = L_W'(tag_in.u) - (jl <<< 15);
    rnum = ((jl + L_W'(coef.ord) + L_W'(1)) <<< 15) - L_W'(tag_in.u);
  end

  // Round, floor by 2^15, clamp, then offset so the divide by p sees a positive value
  always_comb begin
    sum    = (P_W+1)'(prod_l) + (P_W+1)'(prod_r) + (P_W+1)'({coef.ord, 14'b0});
    q      = QS_W'(sum >>> 15);
    q_base = QS_W'({coef.ord, 24'b0});
    q_hi   = q_base + QS_W'(coef.ord) - QS_W'(1);
    q_lo   = -q_base;
    if (q > q_hi) begin
      qc = q_hi;
    end else if (q < q_lo) begin
      qc = q_lo;
    end else begin
      qc = q;
    end
  end

  assign scaled = (Q_W+REC_W)'(qo) * (Q_W+REC_W)'(coef.recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid      <= 1'b0;
      t2.valid      <= 1'b0;
      t3.valid      <= 1'b0;
      tag_out.valid <= 1'b0;
    end else if (en) begin
      t1      <= tag_in;
      t2      <= t1;
      t3      <= t2;
      tag_out <= t3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_l  <= lnum * a;
      prod_r  <= rnum * b;
      qo      <= Q_W'(qc + q_base);
      quo     <= scaled[REC_SH +: V_W];
      val_out <= val_t'(quo) - CLAMP_V;
    end
  end

endmodule

/* design/bbe_front.sv */
// Input holding register, per-request index sequencer and order-0 indicator window.
// Uses bbe_pkg types and widths.
module bbe_front
  import bbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // x_value[15:0]
  output tag_t        tag,
  output window_t     win
);

  localparam logic signed [U_W-1:0] GRID_S = U_W'(GRID_INTERVALS);
  localparam logic signed [U_W-1:0] OFS_S  = U_W'(U_OFS);

  logic                  hold_valid;
  logic signed [15:0]    x_hold;
  logic signed [U_W-1:0] xe;
  logic signed [U_W-1:0] u_new;
  logic                  load;
  tag_t                  cur;

  logic [SP_W-1:0]  span;
  logic [CMP_W-1:0] span_x;
  logic [CMP_W-1:0] sel_x;
  window_t          win_next;

  assign s_tready = !hold_valid;
  assign load     = en && hold_valid && (!cur.valid || cur.last);

  always_comb begin
    xe    = U_W'(x_hold);
    u_new = xe * GRID_S + OFS_S;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && !hold_valid) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && !hold_valid) begin
      x_hold <= s_tdata;
    end
  end

  // Walk the basis indices of the current request, one per cycle while en is high
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      if (load) begin
        cur.valid <= 1'b1;
        cur.idx   <= '0;
        cur.last  <= (N_BASIS == 1);
        cur.u     <= u_new;
      end else if (cur.valid && !cur.last) begin
        cur.idx  <= cur.idx + 1'b1;
        cur.last <= (cur.idx == IDX_W'(N_BASIS - 2));
      end else begin
        cur.valid <= 1'b0;
      end
    end
  end

  // Order-0 indicators for knot intervals idx .. idx + BASIS_DEGREE;
  // beyond the last interval the last indicator stays set
  always_comb begin
    span   = cur.u[U_W-2:15];
    span_x = CMP_W'(span);
    sel_x  = (span_x >= CMP_W'(N_ORDER0)) ? CMP_W'(N_ORDER0 - 1) : span_x;
    for (int k = 0; k <= BASIS_DEGREE; k++) begin
      win_next[k] = (!cur.u[U_W-1] && (sel_x == CMP_W'(cur.idx) + CMP_W'(k))) ? ONE_V : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (en) begin
      tag <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win <= win_next;
    end
  end

endmodule

/* design/bspline_basis_evaluator.sv */
// B-spline basis evaluator top level: front end, triangular chain of recurrence cells,
// output register. Depends on bbe_pkg, bbe_front and bbe_cell.
//
// Each request on the slave stream carries one signed Q2.14 sample x_value. The block
// answers with GRID_INTERVALS + BASIS_DEGREE results (eleven with the default constants),
// one per basis function in ascending index order, each giving basis_index and the unsigned
// Q1.15 basis value saturated to [0, 1.0]; tlast marks the final result of a request.
// The knots are uniform on [-1, 1] with BASIS_DEGREE extra knots on each side. Samples
// below the first knot give all zeros; at or past the last knot the last interval
// indicator is held and the recurrence extrapolates. Internally the front end maps x onto
// the knot axis and issues one basis index per cycle while the chain is enabled, together
// with the order-0 interval indicators it needs. Every following order is a column of
// identical cells, each taking two neighboring values from the previous column and the
// knot distances, so a new index enters the chain every cycle unless the master stream
// stalls. The sequencer issuing one basis index per cycle matches the one result per
// cycle of the master stream. A result passes through the sequencer, the indicator window
// and the output register, plus four stages per cell; the wait for the first result grows
// while an earlier request still occupies the sequencer. One request is buffered at the
// input, so the next sample is taken while results still drain, and a stalled master
// stream holds the whole chain without losing or repeating results.
module bspline_basis_evaluator
  import bbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // x_value[15:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // basis_index[3:0], basis_value[19:4], zero[23:20]
  output logic              m_tlast    // last_of_run
);

  logic    en;
  window_t win [BASIS_DEGREE+1];
  tag_t    tg  [BASIS_DEGREE+1];
  val_t    fin;
  logic [15:0] sat;

  // Advance the whole chain whenever the output register is free or being taken
  assign en = !m_tvalid || m_tready;

  bbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .tag      (tg[0]),
    .win      (win[0])
  );

  // Column p holds N[idx + k, p] for k = 0 .. BASIS_DEGREE - p
  for (genvar p = 1; p <= BASIS_DEGREE; p++) begin : g_order
    localparam logic [REC_W-1:0] RECIP = REC_W'(((64'd1 << REC_SH) + p - 1) / p);
    for (genvar k = 0; k <= BASIS_DEGREE; k++) begin : g_lane
      if (k <= BASIS_DEGREE - p) begin : g_cell
        coef_t coef;
        assign coef.ord    = ORD_W'(p);
        assign coef.offset = ORD_W'(k);
        assign coef.recip  = RECIP;
        if (k == 0) begin : g_lead
          bbe_cell u_cell (
            .clk     (clk),
            .rst     (rst),
            .en      (en),
            .coef    (coef),
            .tag_in  (tg[p-1]),
            .a       (win[p-1][k]),
            .b       (win[p-1][k+1]),
            .tag_out (tg[p]),
            .val_out (win[p][k])
          );
        end else begin : g_follow
          bbe_cell u_cell (
            .clk     (clk),
            .rst     (rst),
            .en      (en),
            .coef    (coef),
            .tag_in  (tg[p-1]),
            .a       (win[p-1][k]),
            .b       (win[p-1][k+1]),
            .tag_out (),
            .val_out (win[p][k])
          );
        end
      end else begin : g_unused
        assign win[p][k] = '0;
      end
    end
  end

  // Saturate the final order to [0, 1.0]
  assign fin = win[BASIS_DEGREE][0];

  always_comb begin
    if (fin < 0) begin
      sat = '0;
    end else if (fin > ONE_V) begin
      sat = 16'(ONE_Q15);
    end else begin
      sat = fin[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= tg[BASIS_DEGREE].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {(DATA_W - 20)'(0), sat, 4'(tg[BASIS_DEGREE].idx)};
      m_tlast <= tg[BASIS_DEGREE].last;
    end
  end

endmodule

/* test/bspline_basis_evaluator_test.sv */
// Self-checking testbench for the B-spline basis evaluator: directed knot and range samples,
// then random samples under several source-idle and sink-stall mixes.
// Depends on bbe_pkg and the bspline_basis_evaluator RTL; needs nothing else.
module bspline_basis_evaluator_test;
  import bbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int KNOT_STEP_X    = 4096;    // one knot spacing in Q2.14 with eight intervals
  localparam int FIRST_KNOT_X   = -28672;  // x at the first knot of the extended vector
  localparam int LAST_KNOT_X    = 28672;   // x at the last order-0 knot

  // One basis value as the block should report it
  typedef struct {
    logic [3:0]  idx;
    logic [15:0] value;
    logic        last;
  } basis_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;   // x_value[15:0]
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;   // basis_index[3:0], basis_value[19:4], zero[23:20]
  logic              m_tlast;   // last_of_run

  basis_result_t basis_expect_q[$];
  int            mismatch_count = 0;
  int            quiet_cycles;
  int            send_idle_pct = 0;
  int            sink_stall_pct = 0;

  bspline_basis_evaluator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the basis values for one sample and queue them in index order.
  // Positions live on the knot axis in units of 2^-15 knot spacing.
  function automatic void predict_basis(input logic signed [15:0] x);
    longint        knot_val[N_ORDER0+1];
    longint        u;
    longint        span;
    longint        lnum;
    longint        rnum;
    longint        acc;
    longint        q;
    longint        divisor;
    longint        clamp_mag;
    int            p;
    int            i;
    int            count;
    basis_result_t r;
    clamp_mag = longint'(1) << CLAMP_LOG;
    u = (longint'(x) + 16384) * GRID_INTERVALS + BASIS_DEGREE * ONE_Q15;
    for (i = 0; i <= N_ORDER0; i++) knot_val[i] = 0;
    // below the first knot nothing is set; past the last knot hold the last indicator
    if (u >= 0) begin
      span = u / ONE_Q15;
      if (span < N_ORDER0) knot_val[span] = ONE_Q15;
      else knot_val[N_ORDER0-1] = ONE_Q15;
    end
    for (p = 1; p <= BASIS_DEGREE; p++) begin
      divisor = p * ONE_Q15;
      count = N_ORDER0 - p;
      for (i = 0; i < count; i++) begin
        lnum = u - longint'(i) * ONE_Q15;
        rnum = longint'(i + p + 1) * ONE_Q15 - u;
        acc = lnum * knot_val[i] + rnum * knot_val[i+1] + divisor / 2;
        // floor division, rounding ties upward
        q = acc / divisor;
        if ((acc % divisor) != 0 && acc < 0) q = q - 1;
        if (q > clamp_mag) q = clamp_mag;
        if (q < -clamp_mag) q = -clamp_mag;
        knot_val[i] = q;
      end
      knot_val[count] = 0;
    end
    for (i = 0; i < N_BASIS; i++) begin
      q = knot_val[i];
      if (q < 0) q = 0;
      if (q > ONE_Q15) q = ONE_Q15;
      r.idx = 4'(i);
      r.value = 16'(q);
      r.last = (i == N_BASIS - 1);
      basis_expect_q.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one sample, idling first at random, and hold it until the block takes it.
  task automatic send_sample(input logic [15:0] x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    predict_basis(x);
  endtask

  // Random sink backpressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Compare each delivered basis value with the oldest one still owed.
  always @(posedge clk) begin : check_results
    basis_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (basis_expect_q.size() == 0) begin
        report_mismatch("unexpected result, basis_index", m_tdata[3:0], -1);
      end else begin
        want = basis_expect_q.pop_front();
        if (m_tdata[3:0] !== want.idx)
          report_mismatch("basis_index", m_tdata[3:0], want.idx);
        if (m_tdata[19:4] !== want.value)
          report_mismatch($sformatf("basis_value[%0d]", want.idx), m_tdata[19:4], want.value);
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last_of_run[%0d]", want.idx), m_tlast, want.last);
        if (m_tdata[DATA_W-1:20] !== '0)
          report_mismatch("tdata padding", m_tdata[DATA_W-1:20], 0);
      end
    end
  end

  // End the run when neither stream moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Field extremes, knot points and both out-of-range regions.
  task automatic test_directed_samples();
    int k;
    send_sample(16'h8000);                 // most negative sample
    send_sample(16'h7FFF);                 // most positive sample
    send_sample(16'h0000);                 // center of the grid
    send_sample(16'hFFFF);                 // just below zero
    send_sample(16'(FIRST_KNOT_X - 1));    // just below the first knot: all zeros
    send_sample(16'(FIRST_KNOT_X));        // exactly on the first knot
    send_sample(16'(FIRST_KNOT_X + 1));
    send_sample(16'(-16384));              // x = -1.0
    send_sample(16'(16383));               // just below x = 1.0
    send_sample(16'(16384));               // x = 1.0
    send_sample(16'(LAST_KNOT_X - 1));     // just inside the last interval
    send_sample(16'(LAST_KNOT_X));         // on the last knot: hold the last indicator
    send_sample(16'(LAST_KNOT_X + 1));     // beyond: extrapolate and saturate
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    // interior knot points hit the interval boundaries exactly
    for (k = 2; k < 14; k += 3) send_sample(16'(FIRST_KNOT_X + k * KNOT_STEP_X));
  endtask

  // Mostly uniform samples, with a share near knots and in the out-of-range tails.
  task automatic test_random_samples(input int idle_pct, input int stall_pct, input int n);
    int          j;
    int          pick;
    int          k;
    logic [15:0] x;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    for (j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        x = 16'($urandom);
      end else if (pick < 85) begin
        k = $urandom_range(0, 14);
        x = 16'(FIRST_KNOT_X + k * KNOT_STEP_X + int'($urandom_range(0, 8)) - 4);
      end else if (pick < 93) begin
        x = 16'(-32768 + int'($urandom_range(0, 32768 + FIRST_KNOT_X - 1)));
      end else begin
        x = 16'(LAST_KNOT_X + int'($urandom_range(0, 32767 - LAST_KNOT_X)));
      end
      send_sample(x);
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    m_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_samples();
    test_random_samples(0, 0, 25);     // full rate, no gaps
    test_random_samples(53, 0, 25);    // sparse source
    test_random_samples(0, 53, 25);    // heavy sink backpressure
    test_random_samples(13, 13, 25);   // light gaps on both sides

    // drop the request and let every owed result arrive
    s_tvalid <= 1'b0;
    while (basis_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
